>>> rtl/siir_pkg.sv
// ----------------------------------------------------------------------------
// siir_pkg
// Shared widths, types and constants of the stereo direct-form-I IIR filter.
// ----------------------------------------------------------------------------
package siir_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int COEF_W     = 24;
	localparam int FRAC_SHIFT = COEF_W - 4;
	localparam int PROD_W     = SAMPLE_W + COEF_W;
	localparam int ACC_W      = PROD_W + 8;

	localparam int NUM_REGS   = 7;
	localparam int REG_IDX_W  = 3;

	localparam int HIST_AW    = 4;
	localparam int HIST_DEPTH = 1 << HIST_AW;

	localparam logic CH_RIGHT = 1'b0;
	localparam logic CH_LEFT  = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;

	localparam coef_t COEF_ONE = coef_t'(1) <<< FRAC_SHIFT;

	localparam logic signed [ACC_W-1:0] ACC_ROUND = ACC_W'(1) << (FRAC_SHIFT - 1);
	localparam logic signed [ACC_W-1:0] ACC_SAT_MAX =
		{{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_SAT_MIN =
		{{(ACC_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic neg;
		logic use_x;
		logic chan;
	} term_ctl_t;

	typedef struct packed {
		logic    valid;
		logic    chan;
		logic    sat;
		sample_t value;
	} mac_res_t;

	typedef struct packed {
		logic               we;
		logic [HIST_AW-1:0] waddr;
		sample_t            wdata;
		logic               re;
		logic [HIST_AW-1:0] raddr;
	} hist_req_t;

endpackage

>>> rtl/siir_in_if.sv
// ----------------------------------------------------------------------------
// siir_in_if
// Request channel carrying one stereo input frame.
// ----------------------------------------------------------------------------
interface siir_in_if import siir_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample_right;
	sample_t sample_left;

	modport source (output valid, sample_right, sample_left, input ready);
	modport sink (input valid, sample_right, sample_left, output ready);
endinterface

>>> rtl/siir_out_if.sv
// ----------------------------------------------------------------------------
// siir_out_if
// Request channel carrying one filtered stereo frame and its clip flag.
// ----------------------------------------------------------------------------
interface siir_out_if import siir_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t filtered_right;
	sample_t filtered_left;
	logic    clipped;

	modport source (output valid, filtered_right, filtered_left, clipped, input ready);
	modport sink (input valid, filtered_right, filtered_left, clipped, output ready);
endinterface

>>> rtl/siir_coef_regs.sv
// ----------------------------------------------------------------------------
// siir_coef_regs
// Coefficient register file with a write port and one selected read.
// ----------------------------------------------------------------------------
module siir_coef_regs import siir_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [COEF_W-1:0]    wr_data,
	input  logic [REG_IDX_W-1:0] rd_index,
	output coef_t                rd_coef
);

	coef_t coef_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				coef_q[i] <= (i == 0) ? COEF_ONE : '0;
			end
		end else if (wr_en && (int'(wr_index) < NUM_REGS)) begin
			coef_q[wr_index] <= coef_t'(wr_data);
		end
	end

	always_comb begin
		rd_coef = '0;
		if (int'(rd_index) < NUM_REGS) begin
			rd_coef = coef_q[rd_index];
		end
	end

endmodule

>>> rtl/siir_hist_mem.sv
// ----------------------------------------------------------------------------
// siir_hist_mem
// Sample history memory with registered read and per-entry valid bits.
// ----------------------------------------------------------------------------
module siir_hist_mem import siir_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  hist_req_t req,
	output sample_t   rdata
);

	sample_t                 mem_q [HIST_DEPTH];
	logic [HIST_DEPTH-1:0]   vld_q;
	sample_t                 rd_q;
	logic                    rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_q <= mem_q[req.raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				rd_vld_q <= vld_q[req.raddr];
			end
		end
	end

	// An entry never written since reset reads as zero.
	assign rdata = rd_vld_q ? rd_q : '0;

`ifndef ASSERT_OFF
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.we && req.re))
		else $error("history memory read and written in the same cycle");
`endif

endmodule

>>> rtl/siir_mac.sv
// ----------------------------------------------------------------------------
// siir_mac
// Shared multiply-accumulate unit with rounding and saturation.
// ----------------------------------------------------------------------------
module siir_mac import siir_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  term_ctl_t ctl,
	input  coef_t     coef,
	input  sample_t   sample,
	output mac_res_t  res
);

	term_ctl_t                  ctl_s3;
	logic signed [PROD_W-1:0]   prod_s3;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       fin_s4;
	logic                       chan_s4;
	mac_res_t                   res_q;

	logic signed [ACC_W-1:0]    prod_ext;
	logic signed [ACC_W-1:0]    acc_next;
	logic signed [ACC_W-1:0]    rnd;
	logic signed [ACC_W-1:0]    shf;

	always_ff @(posedge clk) begin
		prod_s3 <= coef * sample;
		if (ctl_s3.valid) begin
			acc_q <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3  <= '0;
			fin_s4  <= 1'b0;
			chan_s4 <= CH_RIGHT;
			res_q   <= '0;
		end else begin
			ctl_s3  <= ctl;
			fin_s4  <= ctl_s3.valid && ctl_s3.last;
			chan_s4 <= ctl_s3.chan;
			res_q.valid <= fin_s4;
			if (fin_s4) begin
				res_q.chan <= chan_s4;
				if (shf > ACC_SAT_MAX) begin
					res_q.value <= ACC_SAT_MAX[SAMPLE_W-1:0];
					res_q.sat   <= 1'b1;
				end else if (shf < ACC_SAT_MIN) begin
					res_q.value <= ACC_SAT_MIN[SAMPLE_W-1:0];
					res_q.sat   <= 1'b1;
				end else begin
					res_q.value <= shf[SAMPLE_W-1:0];
					res_q.sat   <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		prod_ext = {{(ACC_W-PROD_W){prod_s3[PROD_W-1]}}, prod_s3};
		acc_next = (ctl_s3.first ? '0 : acc_q) + (ctl_s3.neg ? -prod_ext : prod_ext);
		rnd      = acc_q + ACC_ROUND;
		shf      = rnd >>> FRAC_SHIFT;
	end

	assign res = res_q;

endmodule

>>> rtl/stereo_iir_direct_form_one_unit.sv
// ----------------------------------------------------------------------------
// stereo_iir_direct_form_one_unit
// Stereo direct-form-I IIR filter of order three with shared coefficients.
// ----------------------------------------------------------------------------
// The samples channel takes one request holding a right and a left Q1.23
// sample; the filtered channel returns one request per frame with both
// rounded and saturated outputs and a clip flag. Coefficients are written
// through wr_en, wr_index and wr_data while no frame is in progress.
// The fourteen products of a frame run one per cycle through the single
// multiply-accumulate unit, each channel's sum is rounded and saturated in
// its result register, and the new input and output samples of both
// channels are then written into the history memory. The filtered request
// appears in the same cycle that the unit returns to idle and can take the
// next frame. A new frame is taken while the previous result still waits
// in the output register; if the receiver stalls, the unit holds the
// finished frame and stops taking input until the output register frees.
// Reset clears the history, restores the coefficients to a pass-through
// filter and empties the output register.
// ----------------------------------------------------------------------------
module stereo_iir_direct_form_one_unit import siir_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	siir_in_if.sink              samples,
	siir_out_if.source           filtered,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [COEF_W-1:0]    wr_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RUN   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_WB    = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam logic [2:0] TERM_X    = 3'd0;
	localparam logic [2:0] TERM_FB   = 3'd4;
	localparam logic [2:0] TERM_LAST = 3'd6;
	localparam logic [1:0] SLOT_LAST = 2'd2;
	localparam logic [1:0] WB_LAST   = 2'd3;

	logic [2:0] state_q;
	logic       chan_q;
	logic [2:0] term_q;
	logic [1:0] wcnt_q;
	logic [1:0] wp_q;
	sample_t    xr_q;
	sample_t    xl_q;
	sample_t    yr_q;
	sample_t    yl_q;
	logic       sat_q;

	term_ctl_t  ctl_s1;
	term_ctl_t  ctl_s2;
	coef_t      coef_s1;
	coef_t      coef_s2;
	sample_t    x_s2;
	sample_t    hist_rdata;
	sample_t    mac_sample;
	mac_res_t   res;
	hist_req_t  hreq;

	logic       fv_q;
	sample_t    fr_q;
	sample_t    fl_q;
	logic       fc_q;

	logic       is_y;
	logic [2:0] depth;
	logic [2:0] slot_sum;
	logic [1:0] slot;
	logic       out_load;

	siir_coef_regs u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.rd_index (term_q),
		.rd_coef  (coef_s1)
	);

	siir_hist_mem u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hreq),
		.rdata  (hist_rdata)
	);

	siir_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s2),
		.coef   (coef_s2),
		.sample (mac_sample),
		.res    (res)
	);

	// Histories are ring buffers; wp_q is the slot that takes the next sample.
	always_comb begin
		is_y     = (term_q >= TERM_FB);
		depth    = is_y ? (term_q - TERM_FB) : (term_q - 3'd1);
		slot_sum = {1'b0, wp_q} + 3'd2 - depth;
		slot     = (slot_sum >= 3'd3) ? 2'(slot_sum - 3'd3) : slot_sum[1:0];

		ctl_s1.valid = (state_q == ST_RUN);
		ctl_s1.first = (term_q == TERM_X);
		ctl_s1.last  = (term_q == TERM_LAST);
		ctl_s1.neg   = is_y;
		ctl_s1.use_x = (term_q == TERM_X);
		ctl_s1.chan  = chan_q;

		hreq.re    = (state_q == ST_RUN) && (term_q != TERM_X);
		hreq.raddr = {chan_q, is_y, slot};
		hreq.we    = (state_q == ST_WB);
		hreq.waddr = {wcnt_q[0], wcnt_q[1], wp_q};
		case (wcnt_q)
			2'd0:    hreq.wdata = xr_q;
			2'd1:    hreq.wdata = xl_q;
			2'd2:    hreq.wdata = yr_q;
			default: hreq.wdata = yl_q;
		endcase

		mac_sample = ctl_s2.use_x ? x_s2 : hist_rdata;
		out_load   = (state_q == ST_OUT) && (!fv_q || filtered.ready);
	end

	always_ff @(posedge clk) begin
		coef_s2 <= coef_s1;
		x_s2    <= (chan_q == CH_LEFT) ? xl_q : xr_q;
		if (samples.valid && samples.ready) begin
			xr_q <= samples.sample_right;
			xl_q <= samples.sample_left;
		end
		if (res.valid) begin
			if (res.chan == CH_LEFT) begin
				yl_q  <= res.value;
				sat_q <= sat_q | res.sat;
			end else begin
				yr_q  <= res.value;
				sat_q <= res.sat;
			end
		end
		if (out_load) begin
			fr_q <= yr_q;
			fl_q <= yl_q;
			fc_q <= sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chan_q  <= CH_RIGHT;
			term_q  <= TERM_X;
			wcnt_q  <= '0;
			wp_q    <= '0;
			ctl_s2  <= '0;
			fv_q    <= 1'b0;
		end else begin
			ctl_s2 <= ctl_s1;
			if (out_load) begin
				fv_q <= 1'b1;
			end else if (filtered.ready) begin
				fv_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						state_q <= ST_RUN;
						chan_q  <= CH_RIGHT;
						term_q  <= TERM_X;
					end
				end
				ST_RUN: begin
					if (term_q == TERM_LAST) begin
						term_q <= TERM_X;
						if (chan_q == CH_LEFT) begin
							state_q <= ST_DRAIN;
						end else begin
							chan_q <= CH_LEFT;
						end
					end else begin
						term_q <= term_q + 3'd1;
					end
				end
				ST_DRAIN: begin
					if (res.valid && (res.chan == CH_LEFT)) begin
						state_q <= ST_WB;
						wcnt_q  <= '0;
					end
				end
				ST_WB: begin
					wcnt_q <= wcnt_q + 2'd1;
					if (wcnt_q == WB_LAST) begin
						wp_q    <= (wp_q == SLOT_LAST) ? 2'd0 : wp_q + 2'd1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign samples.ready           = (state_q == ST_IDLE);
	assign filtered.valid          = fv_q;
	assign filtered.filtered_right = fr_q;
	assign filtered.filtered_left  = fl_q;
	assign filtered.clipped        = fc_q;

`ifndef ASSERT_OFF
	a_accept_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=>
		(state_q == ST_RUN && term_q == TERM_X && chan_q == CH_RIGHT))
		else $error("accepted frame did not start at the first right term");

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		samples.ready |-> (!ctl_s2.valid && !res.valid))
		else $error("work still in flight while taking a new frame");

	a_result_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (state_q == ST_RUN || state_q == ST_DRAIN))
		else $error("filter result arrived outside the compute phase");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= SLOT_LAST)
		else $error("history write slot out of range");
`endif

endmodule
